// File: src/hkr_pkg.sv
// Shared types and constants for the HID keyboard report builder.
`default_nettype none

package hkr_pkg;

	// Field widths
	localparam int CODE_W       = 7;
	localparam int MOD_W        = 8;
	localparam int REPORT_SLOTS = 6;

	// Code space: ordinary keys below MOD_FIRST, modifiers up to MOD_LAST, rest reserved
	localparam logic [CODE_W-1:0] CODE_EMPTY = 7'h00;
	localparam logic [CODE_W-1:0] MOD_FIRST  = 7'h70;
	localparam logic [CODE_W-1:0] MOD_LAST   = 7'h77;

	// One key event
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              released;
	} key_event_t;

endpackage

`default_nettype wire

// File: src/hkr_slot_update.sv
// Next-state logic for the key slots and modifier byte, given one key event.
`default_nettype none

module hkr_slot_update #(
	parameter int NUM_SLOTS = 6
) (
	input  hkr_pkg::key_event_t               ev,
	input  logic [hkr_pkg::CODE_W-1:0]        slots      [NUM_SLOTS],
	input  logic [hkr_pkg::MOD_W-1:0]         mods,
	output logic [hkr_pkg::CODE_W-1:0]        slots_next [NUM_SLOTS],
	output logic [hkr_pkg::MOD_W-1:0]         mods_next
);

	logic [NUM_SLOTS-1:0]      match;
	logic [NUM_SLOTS-1:0]      empty;
	logic [NUM_SLOTS-1:0]      first_free;
	logic                      present;
	logic                      is_key;
	logic                      is_mod;
	logic [hkr_pkg::MOD_W-1:0] mod_sel;

	// Event class
	assign is_key = (ev.code < hkr_pkg::MOD_FIRST) && (ev.code != hkr_pkg::CODE_EMPTY);
	assign is_mod = (ev.code >= hkr_pkg::MOD_FIRST) && (ev.code <= hkr_pkg::MOD_LAST);

	// Per-slot compares
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			match[i] = (slots[i] == ev.code);
			empty[i] = (slots[i] == hkr_pkg::CODE_EMPTY);
		end
	end

	assign present = |match;
	// lowest set bit of the empty mask
	assign first_free = empty & (~empty + NUM_SLOTS'(1));

	// Slot update: release clears all matches, press of a key not yet held fills lowest empty slot
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slots_next[i] = slots[i];
			if (is_key) begin
				if (ev.released) begin
					if (match[i]) begin
						slots_next[i] = hkr_pkg::CODE_EMPTY;
					end
				end else if (!present && first_free[i]) begin
					slots_next[i] = ev.code;
				end
			end
		end
	end

	// Modifier byte
	assign mod_sel = hkr_pkg::MOD_W'(1) << ev.code[2:0];

	always_comb begin
		mods_next = mods;
		if (is_mod) begin
			if (ev.released) begin
				mods_next = mods & ~mod_sel;
			end else begin
				mods_next = mods | mod_sel;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/hid_keyboard_report_builder.sv
// Top level of the HID boot keyboard report builder (6-key rollover).
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_ready  | key_code[6:0], released
//  output  | out_valid, out_ready| modifier_bits[7:0], slot_zero..slot_five
//
// One item per cycle sustained while out_ready stays high. An accepted item
// is held in the input register; the slot compare and priority pick then
// write the state registers, which also drive the report and raise out_valid.
// Reset clears the slots and modifiers (empty report) and both valid flags.
// A stalled report holds the state, and the input register then fills and
// drops in_ready.
`default_nettype none

module hid_keyboard_report_builder #(
	parameter int NUM_KEY_SLOTS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hkr_pkg::CODE_W-1:0]   key_code,
	input  logic                         released,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hkr_pkg::MOD_W-1:0]    modifier_bits,
	output logic [hkr_pkg::CODE_W-1:0]   slot_zero,
	output logic [hkr_pkg::CODE_W-1:0]   slot_one,
	output logic [hkr_pkg::CODE_W-1:0]   slot_two,
	output logic [hkr_pkg::CODE_W-1:0]   slot_three,
	output logic [hkr_pkg::CODE_W-1:0]   slot_four,
	output logic [hkr_pkg::CODE_W-1:0]   slot_five
);

	hkr_pkg::key_event_t             ev_s1;
	logic                            valid_s1;
	logic                            advance;
	logic                            out_valid_q;
	logic [hkr_pkg::CODE_W-1:0]      slots_q    [NUM_KEY_SLOTS];
	logic [hkr_pkg::CODE_W-1:0]      slots_next [NUM_KEY_SLOTS];
	logic [hkr_pkg::MOD_W-1:0]       mods_q;
	logic [hkr_pkg::MOD_W-1:0]       mods_next;
	logic [hkr_pkg::CODE_W-1:0]      report     [hkr_pkg::REPORT_SLOTS];

	// Handshake: the event moves on whenever the report slot is free or taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ev_s1 <= '{code: key_code, released: released};
		end
	end

	// Next-state logic
	hkr_slot_update #(
		.NUM_SLOTS (NUM_KEY_SLOTS)
	) u_update (
		.ev         (ev_s1),
		.slots      (slots_q),
		.mods       (mods_q),
		.slots_next (slots_next),
		.mods_next  (mods_next)
	);

	// State registers, which double as the report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
			for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
				slots_q[i] <= hkr_pkg::CODE_EMPTY;
			end
		end else if (advance) begin
			mods_q <= mods_next;
			for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
				slots_q[i] <= slots_next[i];
			end
		end
	end

	// Report valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Report slots: slots past the configured count read empty
	for (genvar k = 0; k < hkr_pkg::REPORT_SLOTS; k++) begin : g_report
		if (k < NUM_KEY_SLOTS) begin : g_used
			assign report[k] = slots_q[k];
		end else begin : g_unused
			assign report[k] = hkr_pkg::CODE_EMPTY;
		end
	end

	assign out_valid     = out_valid_q;
	assign modifier_bits = mods_q;
	assign slot_zero     = report[0];
	assign slot_one      = report[1];
	assign slot_two      = report[2];
	assign slot_three    = report[3];
	assign slot_four     = report[4];
	assign slot_five     = report[5];

endmodule

`default_nettype wire

// File: src/hkr_checker.sv
// Port-level checks for the keyboard report builder, bound to the top level.
`default_nettype none

module hkr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [hkr_pkg::CODE_W-1:0]  key_code,
	input logic                        released,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [hkr_pkg::MOD_W-1:0]   modifier_bits,
	input logic [hkr_pkg::CODE_W-1:0]  slot_zero,
	input logic [hkr_pkg::CODE_W-1:0]  slot_one,
	input logic [hkr_pkg::CODE_W-1:0]  slot_two,
	input logic [hkr_pkg::CODE_W-1:0]  slot_three,
	input logic [hkr_pkg::CODE_W-1:0]  slot_four,
	input logic [hkr_pkg::CODE_W-1:0]  slot_five
);

	// A waiting key event stays valid with the same payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(key_code) && $stable(released))
		else $error("key event changed while waiting");

	// A stalled report stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("report dropped while stalled");

	// A stalled report keeps its contents
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(modifier_bits) && $stable(slot_zero)
			&& $stable(slot_one) && $stable(slot_two) && $stable(slot_three)
			&& $stable(slot_four) && $stable(slot_five))
		else $error("report changed while stalled");

	// Every accepted item is followed by out_valid once it has passed the input and state registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no report after accepted item");

	// A filled first slot never repeats in a later slot and holds only an ordinary key code
	a_slot_unique: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot_zero == hkr_pkg::CODE_EMPTY || (slot_zero < hkr_pkg::MOD_FIRST
			&& slot_zero != slot_one && slot_zero != slot_two
			&& slot_zero != slot_three && slot_zero != slot_four
			&& slot_zero != slot_five)))
		else $error("first slot duplicated or out of range");

endmodule

bind hid_keyboard_report_builder hkr_checker u_hkr_checker (.*);

`default_nettype wire

// File: verif/report_checker.sv
// Channel monitor for the keyboard report builder: predicts every report and compares it.
module report_checker #(
	parameter int NUM_SLOTS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [hkr_pkg::CODE_W-1:0] key_code,
	input  logic                       released,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [hkr_pkg::MOD_W-1:0]  modifier_bits,
	input  logic [hkr_pkg::CODE_W-1:0] slot_zero,
	input  logic [hkr_pkg::CODE_W-1:0] slot_one,
	input  logic [hkr_pkg::CODE_W-1:0] slot_two,
	input  logic [hkr_pkg::CODE_W-1:0] slot_three,
	input  logic [hkr_pkg::CODE_W-1:0] slot_four,
	input  logic [hkr_pkg::CODE_W-1:0] slot_five,
	output int                         events_taken,
	output int                         reports_checked,
	output int                         reports_owed,
	output int                         mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	// keys[0] is the first report slot
	typedef struct packed {
		logic [hkr_pkg::MOD_W-1:0]                              mods;
		logic [hkr_pkg::REPORT_SLOTS-1:0][hkr_pkg::CODE_W-1:0] keys;
	} key_report_t;

	// Predicted keyboard state
	logic [hkr_pkg::MOD_W-1:0]  held_mods;
	logic [hkr_pkg::CODE_W-1:0] held_keys [NUM_SLOTS];

	key_report_t owed_q [$];
	key_report_t seen;

	assign seen = {modifier_bits, slot_five, slot_four, slot_three, slot_two, slot_one, slot_zero};

	// Apply one key event to the predicted state and return the report it produces
	function automatic key_report_t apply_key_event(logic [hkr_pkg::CODE_W-1:0] code, logic rel);
		int          free_idx;
		bit          already;
		key_report_t rpt;
		free_idx = -1;
		already  = 1'b0;
		if (code < hkr_pkg::MOD_FIRST) begin
			// code zero marks an empty slot, so it never changes anything
			if (code != hkr_pkg::CODE_EMPTY) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (held_keys[i] == code) begin
						already = 1'b1;
						if (rel)
							held_keys[i] = hkr_pkg::CODE_EMPTY;
					end else if (held_keys[i] == hkr_pkg::CODE_EMPTY && free_idx < 0) begin
						free_idx = i;
					end
				end
				// press: lowest empty slot, no duplicates, dropped when full
				if (!rel && !already && free_idx >= 0)
					held_keys[free_idx] = code;
			end
		end else if (code <= hkr_pkg::MOD_LAST) begin
			held_mods[code - hkr_pkg::MOD_FIRST] = !rel;
		end
		// reserved codes fall through with no change
		rpt.mods = held_mods;
		for (int k = 0; k < hkr_pkg::REPORT_SLOTS; k++)
			rpt.keys[k] = (k < NUM_SLOTS) ? held_keys[k] : hkr_pkg::CODE_EMPTY;
		return rpt;
	endfunction

	// Sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		key_report_t want;
		if (!arst_n) begin
			held_mods = '0;
			foreach (held_keys[i])
				held_keys[i] = hkr_pkg::CODE_EMPTY;
			owed_q.delete();
			events_taken    = 0;
			reports_checked = 0;
			reports_owed    = 0;
			mismatches      = 0;
		end else begin
			// report side: compare against the oldest prediction
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					mismatches++;
					$display("%0t: report with none expected: mods %02h slots %h", $time,
						seen.mods, seen.keys);
				end else begin
					want = owed_q.pop_front();
					if (want.mods !== seen.mods) begin
						mismatches++;
						$display("%0t: modifier_bits expected %02h got %02h", $time,
							want.mods, seen.mods);
					end
					for (int k = 0; k < hkr_pkg::REPORT_SLOTS; k++) begin
						if (want.keys[k] !== seen.keys[k]) begin
							mismatches++;
							$display("%0t: slot %0d expected %02h got %02h", $time, k,
								want.keys[k], seen.keys[k]);
						end
					end
				end
				reports_checked++;
			end
			// event side: every accepted item yields exactly one report
			if (in_valid && in_ready) begin
				owed_q.push_back(apply_key_event(key_code, released));
				events_taken++;
			end
			reports_owed = owed_q.size();
		end
	end

endmodule

// File: verif/testbench.sv
// Testbench top for the keyboard report builder: clock, reset, key event stimulus, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [hkr_pkg::CODE_W-1:0] code_t;

	localparam logic KEY_DOWN = 1'b0;
	localparam logic KEY_UP   = 1'b1;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [hkr_pkg::CODE_W-1:0] key_code;
	logic                       released;
	logic                       out_valid;
	logic                       out_ready;
	logic [hkr_pkg::MOD_W-1:0]  modifier_bits;
	logic [hkr_pkg::CODE_W-1:0] slot_zero;
	logic [hkr_pkg::CODE_W-1:0] slot_one;
	logic [hkr_pkg::CODE_W-1:0] slot_two;
	logic [hkr_pkg::CODE_W-1:0] slot_three;
	logic [hkr_pkg::CODE_W-1:0] slot_four;
	logic [hkr_pkg::CODE_W-1:0] slot_five;

	int events_taken;
	int reports_checked;
	int reports_owed;
	int mismatches;
	int sent;
	bit steady;

	hid_keyboard_report_builder #(.NUM_KEY_SLOTS(6)) DUT (.*);

	report_checker #(.NUM_SLOTS(6)) CHECK (.*);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Send one key event after a random gap; returns at the falling edge after acceptance
	task automatic send_key(input logic [hkr_pkg::CODE_W-1:0] code, input logic rel);
		int gap;
		int target;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		key_code <= code;
		released <= rel;
		target = events_taken + 1;
		do @(negedge clk); while (events_taken < target);
		sent++;
	endtask

	// Hold off until every predicted report has been seen
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (reports_owed != 0);
	endtask

	// Random events: mostly a small pool of ordinary keys so slots fill, drain and overflow
	task automatic random_events(input int count);
		logic [hkr_pkg::CODE_W-1:0] pool [8];
		logic [hkr_pkg::CODE_W-1:0] code;
		int                         pick;
		foreach (pool[i])
			pool[i] = code_t'($urandom_range(1, hkr_pkg::MOD_FIRST - 1));
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				code = pool[$urandom_range(0, 7)];
			else if (pick < 75)
				code = hkr_pkg::MOD_FIRST + code_t'($urandom_range(0, 7));
			else if (pick < 80)
				code = code_t'($urandom_range(hkr_pkg::MOD_LAST + 1, 7'h7F));
			else if (pick < 84)
				code = hkr_pkg::CODE_EMPTY;
			else
				code = code_t'($urandom_range(0, 7'h7F));
			send_key(code, 1'($urandom_range(0, 1)));
		end
	endtask

	// Report side: random stalls per item, none while steady
	initial begin
		int stall;
		int target;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			target = reports_checked + 1;
			do @(negedge clk); while (reports_checked < target);
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		key_code = hkr_pkg::CODE_EMPTY;
		released = KEY_DOWN;
		sent     = 0;
		steady   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty code, duplicates, reserved codes, modifier edges, full slots
		send_key(hkr_pkg::CODE_EMPTY, KEY_DOWN);
		send_key(hkr_pkg::CODE_EMPTY, KEY_UP);
		send_key(7'h04, KEY_DOWN);
		send_key(7'h05, KEY_DOWN);
		send_key(7'h04, KEY_DOWN);
		send_key(7'h7F, KEY_DOWN);
		send_key(7'h78, KEY_UP);
		send_key(hkr_pkg::MOD_FIRST, KEY_DOWN);
		send_key(hkr_pkg::MOD_LAST, KEY_DOWN);
		send_key(hkr_pkg::MOD_FIRST, KEY_UP);
		send_key(7'h01, KEY_DOWN);
		send_key(7'h6F, KEY_DOWN);
		send_key(7'h2A, KEY_DOWN);
		send_key(7'h55, KEY_DOWN);
		send_key(7'h3C, KEY_DOWN);
		send_key(7'h05, KEY_UP);
		send_key(7'h3C, KEY_DOWN);
		send_key(7'h11, KEY_UP);
		send_key(hkr_pkg::MOD_LAST, KEY_UP);
		send_key(7'h7F, KEY_UP);
		send_key(7'h04, KEY_UP);
		send_key(hkr_pkg::MOD_FIRST + code_t'(3), KEY_DOWN);
		wait_idle();

		// random phases, one of them back to back on both sides
		random_events(150);
		wait_idle();
		steady = 1'b1;
		random_events(100);
		steady = 1'b0;
		random_events(150);
		wait_idle();
		random_events(100);

		wait_idle();
		repeat (4) @(negedge clk);

		$display("Ran %0d key events (directed, random with stalls, back to back); %0d reports compared.",
			sent, reports_checked);
		if (reports_owed != 0)
			$display("%0t: %0d expected reports never arrived", $time, reports_owed);
		if (mismatches == 0 && reports_owed == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: files.f
src/hkr_pkg.sv
src/hkr_slot_update.sv
src/hid_keyboard_report_builder.sv
src/hkr_checker.sv
verif/report_checker.sv
verif/testbench.sv
